[rtl/frustum_cull_test_unit_defines.svh]
// ----------------------------------------------------------------------------
// Frustum cull test unit assertion macros
// Shared assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH
`define FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent
`define FCULL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent
`define FCULL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fcull_pkg.sv]
// ----------------------------------------------------------------------------
// Frustum cull package
// Control word shared between the sequencer and the root/divide unit.
// ----------------------------------------------------------------------------
package fcull_pkg;

	// Start request for the shared root/divide unit
	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} fcull_ctl_t;

endpackage

[rtl/fcull_ram.sv]
// ----------------------------------------------------------------------------
// Frustum cull generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fcull_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word through a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/fcull_rsd.sv]
// ----------------------------------------------------------------------------
// Frustum cull root/divide unit
// Restoring integer square root (2 bits a step) or division (1 bit a step)
// over one shared compare and subtract.
// ----------------------------------------------------------------------------
module fcull_rsd
	import fcull_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  fcull_ctl_t  ctl,
	input  logic [63:0] a,       // radicand, or dividend left-aligned
	input  logic [32:0] d,       // divisor
	output logic        busy,
	output logic        done,
	output logic [63:0] res      // root or quotient, right-aligned
);

	localparam int DIV_STEPS  = 32 + FRAC_BITS;
	localparam int SQRT_STEPS = 32;

	logic        busy_q;
	logic        done_q;
	logic        mode_q;
	logic [5:0]  cnt_q;
	logic [63:0] x_q;
	logic [35:0] rem_q;
	logic [63:0] q_q;
	logic [32:0] d_q;

	logic [35:0] rem_n;
	logic [35:0] trial;
	logic        ge;
	logic [35:0] diff;

	// Bring down the next digit and form the trial subtrahend
	always_comb begin
		if (mode_q) begin
			rem_n = {rem_q[33:0], x_q[63:62]};
			trial = {q_q[33:0], 2'b01};
		end else begin
			rem_n = {rem_q[34:0], x_q[63]};
			trial = {3'b000, d_q};
		end
		ge   = rem_n >= trial;
		diff = rem_n - trial;
	end

	// Step the recurrence once a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.sqrt_mode ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.sqrt_mode;
			x_q    <= a;
			rem_q  <= '0;
			q_q    <= '0;
			d_q    <= d;
		end else if (busy_q) begin
			x_q   <= mode_q ? {x_q[61:0], 2'b00} : {x_q[62:0], 1'b0};
			rem_q <= ge ? diff : rem_n;
			q_q   <= {q_q[62:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = q_q;

endmodule

[rtl/frustum_cull_test_unit.sv]
// With planes current, an item runs T_RUN and T_DRN, then FIN registers the result word.
// After any configuration write the next item first rebuilds six planes,
// taking a root and divisions from the root/divide unit.
// Items do not overlap: one is taken only in IDLE; one coefficient product a cycle.
// Reset: identity matrix, planes marked for rebuild, no result pending.
// ----------------------------------------------------------------------------
// Frustum cull test unit
// Builds six normalised clip planes from a view-projection matrix and tests
// a box (positive vertex) or a sphere against them.
// ----------------------------------------------------------------------------
`include "frustum_cull_test_unit_defines.svh"

module frustum_cull_test_unit
	import fcull_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// min_x[31:0] min_y[63:32] min_z[95:64] max_x[127:96] max_y[159:128]
	// max_z[191:160] radius[222:192], zero pad [223]
	input  logic [223:0] s_axis_tdata,
	input  logic         s_axis_tuser,  // command: 0 box, 1 sphere
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [7:0]   m_axis_tdata,  // visible[0], zero pad [7:1]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

	typedef enum logic [10:0] {
		IDLE   = 11'b00000000001,
		B_RAW  = 11'b00000000010,
		B_MUL  = 11'b00000000100,
		B_ACC  = 11'b00000001000,
		B_RT   = 11'b00000010000,
		B_RTW  = 11'b00000100000,
		B_DV   = 11'b00001000000,
		B_DVW  = 11'b00010000000,
		T_RUN  = 11'b00100000000,
		T_DRN  = 11'b01000000000,
		FIN    = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [7:0][63:0]   cfg_q;
	logic               stale_q;
	logic               sphere_q;
	logic signed [31:0] mn_q [3];
	logic signed [31:0] mx_q [3];
	logic [67:0]        extra_q;
	logic [67:0]        acc_q;
	logic               vis_q;
	logic               out_valid_q;
	logic               out_vis_q;

	logic [2:0]         p_q;
	logic [1:0]         j_q;
	logic [4:0]         cnt_q;
	logic signed [31:0] raw_q [4];
	logic [63:0]        sq_q;
	logic [32:0]        len_q;

	logic               v_s1;
	logic [1:0]         j_s1;
	logic               v_s2;
	logic [1:0]         j_s2;
	logic signed [63:0] prod_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [31:0] pt;
	logic signed [31:0] rdata;
	logic [31:0]        ram_rdata_w;
	logic [1:0]         axis_row;
	logic signed [31:0] raw_n [4];
	logic [31:0]        mag;
	logic [63:0]        quo;
	logic [31:0]        coeff_n;
	logic               ram_we;
	logic [67:0]        acc_n;
	logic [67:0]        extra_n;
	logic               s_fire;
	logic               out_free;
	logic               coeff_last;
	logic               planes_built;

	fcull_ctl_t  u_ctl;
	logic        u_busy;
	logic        u_done;
	logic [63:0] u_res;

	// Matrix entry at column col, row row
	function automatic logic signed [31:0] mat_entry(input logic [7:0][63:0] r,
			input logic [1:0] col, input logic [1:0] row);
		logic [63:0] w;
		w = r[{col, row[1]}];
		return row[0] ? w[63:32] : w[31:0];
	endfunction

	// Row 3 plus or minus the axis row, saturated to 32 bits
	function automatic logic signed [31:0] plane_raw(input logic signed [31:0] w,
			input logic signed [31:0] e, input logic minus);
		logic signed [32:0] s;
		s = minus ? (33'(w) - 33'(e)) : (33'(w) + 33'(e));
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return s[31:0];
	endfunction

	assign s_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free     = !out_valid_q || m_axis_tready;
	assign coeff_last   = (j_q == 2'd3);
	assign axis_row     = 2'd2 - p_q[2:1];
	assign extra_n      = s_axis_tuser ? (68'(s_axis_tdata[222:192]) << FRAC_BITS) : '0;

	// Raw plane coefficients for the current plane
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			raw_n[k] = plane_raw(mat_entry(cfg_q, 2'(k), 2'd3),
				mat_entry(cfg_q, 2'(k), axis_row), p_q[0]);
		end
	end

	// Magnitude, quotient and saturated coefficient
	always_comb begin
		mag = raw_q[j_q][31] ? (32'd0 - raw_q[j_q]) : raw_q[j_q];
		quo = u_res;
		if (len_q == '0) begin
			coeff_n = '0;
		end else if (raw_q[j_q][31]) begin
			coeff_n = (quo > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo[31:0]);
		end else begin
			coeff_n = (quo > 64'h7fff_ffff) ? 32'h7fff_ffff : quo[31:0];
		end
	end

	// Start the root/divide unit
	always_comb begin
		u_ctl.start     = (state_q == B_RT) || (state_q == B_DV && len_q != '0);
		u_ctl.sqrt_mode = (state_q == B_RT);
	end

	assign ram_we       = (state_q == B_DV && len_q == '0) || (state_q == B_DVW && u_done);
	assign planes_built = ram_we && coeff_last && (p_q == 3'd5);

	// Test point for the coefficient on the read port
	always_comb begin
		unique case (j_s1)
			2'd0:    pt = (sphere_q || rdata[31]) ? mn_q[0] : mx_q[0];
			2'd1:    pt = (sphere_q || rdata[31]) ? mn_q[1] : mx_q[1];
			2'd2:    pt = (sphere_q || rdata[31]) ? mn_q[2] : mx_q[2];
			default: pt = ONE_FX;
		endcase
	end

	// Share the multiplier between squares and dot products
	always_comb begin
		if (state_q == B_MUL) begin
			mul_a = raw_q[j_q];
			mul_b = raw_q[j_q];
		end else begin
			mul_a = rdata;
			mul_b = pt;
		end
	end

	assign acc_n = acc_q + 68'(prod_q);

	// Multiply, registered
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cfg_q       <= {{ONE_FX, 32'd0}, 64'd0, {32'd0, ONE_FX}, 64'd0,
				64'd0, {ONE_FX, 32'd0}, 64'd0, {32'd0, ONE_FX}};
			stale_q     <= 1'b1;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			p_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q[cfg_index] <= cfg_data;
				stale_q          <= 1'b1;
			end else if (planes_built) begin
				stale_q <= 1'b0;
			end
			if (state_q == FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= (state_q == T_RUN);
			v_s2 <= v_s1;

			unique case (state_q)
				IDLE: begin
					if (s_fire) begin
						p_q     <= '0;
						j_q     <= '0;
						cnt_q   <= '0;
						state_q <= stale_q ? B_RAW : T_RUN;
					end
				end
				B_RAW: begin
					j_q     <= '0;
					state_q <= B_MUL;
				end
				B_MUL: begin
					state_q <= B_ACC;
				end
				B_ACC: begin
					if (j_q == 2'd2) begin
						j_q     <= '0;
						state_q <= B_RT;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= B_MUL;
					end
				end
				B_RT: begin
					state_q <= B_RTW;
				end
				B_RTW: begin
					if (u_done) begin
						state_q <= B_DV;
					end
				end
				B_DV, B_DVW: begin
					if (ram_we) begin
						if (!coeff_last) begin
							j_q     <= j_q + 2'd1;
							state_q <= B_DV;
						end else if (p_q == 3'd5) begin
							p_q     <= '0;
							j_q     <= '0;
							cnt_q   <= '0;
							state_q <= T_RUN;
						end else begin
							p_q     <= p_q + 3'd1;
							state_q <= B_RAW;
						end
					end else begin
						state_q <= B_DVW;
					end
				end
				T_RUN: begin
					if (cnt_q == 5'd23) begin
						state_q <= T_DRN;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				T_DRN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			sphere_q <= s_axis_tuser;
			mn_q[0]  <= s_axis_tdata[31:0];
			mn_q[1]  <= s_axis_tdata[63:32];
			mn_q[2]  <= s_axis_tdata[95:64];
			mx_q[0]  <= s_axis_tdata[127:96];
			mx_q[1]  <= s_axis_tdata[159:128];
			mx_q[2]  <= s_axis_tdata[191:160];
			extra_q  <= extra_n;
			acc_q    <= extra_n;
			vis_q    <= 1'b1;
		end else if (v_s2) begin
			if (j_s2 == 2'd3) begin
				vis_q <= vis_q & ~acc_n[67];
				acc_q <= extra_q;
			end else begin
				acc_q <= acc_n;
			end
		end
		if (state_q == B_RAW) begin
			raw_q <= raw_n;
			sq_q  <= '0;
		end
		if (state_q == B_ACC) begin
			sq_q <= sq_q + prod_q;
		end
		if (state_q == B_RTW && u_done) begin
			len_q <= u_res[32:0];
		end
		j_s1 <= cnt_q[1:0];
		j_s2 <= j_s1;
		if (state_q == FIN && out_free) begin
			out_vis_q <= vis_q;
		end
	end

	assign rdata = $signed(ram_rdata_w);

	fcull_ram #(
		.WIDTH(32),
		.DEPTH(24)
	) u_coeffs (
		.clk  (clk),
		.we   (ram_we),
		.waddr({p_q, j_q}),
		.wdata(coeff_n),
		.raddr(cnt_q),
		.rdata(ram_rdata_w)
	);

	fcull_rsd #(
		.FRAC_BITS(FRAC_BITS)
	) u_rsd (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (u_ctl),
		.a     (u_ctl.sqrt_mode ? sq_q : {mag, 32'd0}),
		.d     (len_q),
		.busy  (u_busy),
		.done  (u_done),
		.res   (u_res)
	);

	assign s_axis_tready = (state_q == IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_vis_q};

	`FCULL_ASSERT_SAME(a_idle_unit_free, s_axis_tready, !u_busy, "root/divide unit busy while idle")
	`FCULL_ASSERT_NEXT(a_cfg_marks_stale, cfg_valid && cfg_ready, stale_q, "config write did not mark planes stale")
	`FCULL_ASSERT_SAME(a_test_fresh, state_q == T_RUN, !stale_q, "plane test on stale planes")

endmodule

[bench/frustum_cull_test_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum cull test unit checker
// Watches the configuration, item and result channels, keeps its own image of
// the matrix and the six normalised planes, predicts the visible flag of each
// accepted item and compares it with the result words in order.
// ----------------------------------------------------------------------------
module frustum_cull_test_unit_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	// min_x[31:0] min_y[63:32] min_z[95:64] max_x[127:96] max_y[159:128]
	// max_z[191:160] radius[222:192], zero pad [223]
	input  logic [223:0] s_axis_tdata,
	input  logic         s_axis_tuser,  // command: 0 box, 1 sphere
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [7:0]   m_axis_tdata,  // visible[0], zero pad [7:1]
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	output int           errors,
	output int           outstanding
);

	localparam logic CMD_BOX    = 1'b0;
	localparam logic CMD_SPHERE = 1'b1;
	localparam int   NUM_PLANES = 6;

	logic [63:0]        matrix_regs [8];
	logic signed [31:0] plane_tab [NUM_PLANES*4];
	logic               planes_dirty;
	logic               visible_q [$];
	int                 result_count;

	function automatic longint matrix_entry(int col, int row);
		logic [63:0] r;
		r = matrix_regs[col*2 + row/2];
		return longint'(signed'(row[0] ? r[63:32] : r[31:0]));
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Floor square root, two bits per step
	function automatic logic [63:0] floor_root(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] probe;
		res   = '0;
		probe = 64'd1 << 62;
		while (probe > x)
			probe = probe >> 2;
		while (probe != 0) begin
			if (x >= res + probe) begin
				x   = x - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	// Rebuild planes: near, far, bottom, top, left, right
	task automatic rebuild_planes();
		longint      raw [4];
		longint      e, w, r;
		logic [63:0] sq, len, mag, q;
		int          row;
		for (int p = 0; p < NUM_PLANES; p++) begin
			row = (p < 2) ? 2 : (p < 4) ? 1 : 0;
			for (int j = 0; j < 4; j++) begin
				e = matrix_entry(j, row);
				w = matrix_entry(j, 3);
				raw[j] = clamp32(p[0] ? (w - e) : (w + e));
			end
			sq = '0;
			for (int j = 0; j < 3; j++)
				sq = sq + 64'(raw[j] * raw[j]);
			len = floor_root(sq);
			for (int j = 0; j < 4; j++) begin
				if (len == 0) begin
					r = 0;
				end else begin
					mag = 64'(raw[j] < 0 ? -raw[j] : raw[j]);
					q   = (mag << FRAC_BITS) / len;
					if (raw[j] < 0)
						r = (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
					else
						r = (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
				end
				plane_tab[p*4 + j] = r[31:0];
			end
		end
		planes_dirty = 1'b0;
	endtask

	// Visible unless some plane gives a negative exact distance
	function automatic logic predict_visible(logic cmd, logic [223:0] d);
		longint              lo [3], hi [3], pt [3];
		logic signed [127:0] acc, extra;
		extra = '0;
		for (int j = 0; j < 3; j++) begin
			lo[j] = longint'(signed'(d[32*j +: 32]));
			hi[j] = longint'(signed'(d[96 + 32*j +: 32]));
		end
		if (cmd == CMD_SPHERE)
			extra = 128'(d[222:192]) <<< FRAC_BITS;
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int j = 0; j < 3; j++) begin
				if (cmd == CMD_BOX)
					pt[j] = (plane_tab[p*4 + j] >= 0) ? hi[j] : lo[j];
				else
					pt[j] = lo[j];
			end
			acc = extra;
			for (int j = 0; j < 3; j++)
				acc = acc + 128'(longint'(plane_tab[p*4 + j]) * pt[j]);
			acc = acc + (128'(longint'(plane_tab[p*4 + 3])) <<< FRAC_BITS);
			if (acc < 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report(string what, logic got, logic want);
		errors++;
		$display("result %0d: %s got %0b expected %0b", result_count, what, got, want);
	endtask

	initial begin
		errors       = 0;
		result_count = 0;
	end

	assign outstanding = visible_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_regs[0] = 64'h0000_0000_0001_0000;
			matrix_regs[1] = '0;
			matrix_regs[2] = 64'h0001_0000_0000_0000;
			matrix_regs[3] = '0;
			matrix_regs[4] = '0;
			matrix_regs[5] = 64'h0000_0000_0001_0000;
			matrix_regs[6] = '0;
			matrix_regs[7] = 64'h0001_0000_0000_0000;
			planes_dirty   = 1'b1;
			visible_q.delete();
		end else begin
			// Track configuration writes
			if (cfg_valid && cfg_ready) begin
				matrix_regs[cfg_index] = cfg_data;
				planes_dirty           = 1'b1;
			end
			// Predict each accepted item
			if (s_axis_tvalid && s_axis_tready) begin
				if (planes_dirty)
					rebuild_planes();
				visible_q.push_back(predict_visible(s_axis_tuser, s_axis_tdata));
			end
			// Compare each result word with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (visible_q.size() == 0) begin
					report("word with no item pending", m_axis_tdata[0], 1'bx);
				end else if (m_axis_tdata[0] !== visible_q[0]) begin
					report("visible", m_axis_tdata[0], visible_q[0]);
				end
				if (visible_q.size() != 0)
					void'(visible_q.pop_front());
				result_count++;
			end
		end
	end

endmodule

[bench/frustum_cull_test_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum cull test unit testbench
// Drives box and sphere items in bursts through several view matrices,
// including identity, saturating, degenerate and random ones, while the
// result side stalls on its own pattern; the checker scores every word.
// ----------------------------------------------------------------------------
module frustum_cull_test_unit_tb;

	localparam logic CMD_BOX    = 1'b0;
	localparam logic CMD_SPHERE = 1'b1;
	localparam int   CYCLE_LIMIT = 600000;
	localparam int   DRAIN_CYCLES = 40;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [223:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [7:0]   m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;
	int           errors;
	int           outstanding;
	int           burst_left;
	logic [63:0]  matrix_set [8];

	frustum_cull_test_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	frustum_cull_test_unit_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up after a generous cycle count
	initial begin
		for (int c = 0; c < CYCLE_LIMIT; c++)
			@(posedge clk);
		$display("frustum_cull_test_unit: mismatch");
		$finish;
	end

	// Result side: the stall pattern is redrawn at random from four modes
	initial begin
		int mode;
		m_axis_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat (64) begin
				@(negedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Send one word, idling between bursts
	task automatic send_item(logic cmd, logic [223:0] d);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8))
				@(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= d;
		do
			@(posedge clk);
		while (!s_axis_tready);
		burst_left--;
		@(negedge clk);
	endtask

	function automatic logic [223:0] pack_item(logic [31:0] lx, logic [31:0] ly,
		logic [31:0] lz, logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
		logic [30:0] rad);
		return {1'b0, rad, hz, hy, hx, lz, ly, lx};
	endfunction

	// Coordinate near the unit frustum, or anywhere
	function automatic logic [31:0] pick_coord(bit wide);
		if (wide)
			return $urandom;
		return 32'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000;
	endfunction

	task automatic send_random(int count);
		logic [31:0] lo [3];
		logic [31:0] hi [3];
		logic [30:0] rad;
		bit          wide;
		for (int n = 0; n < count; n++) begin
			wide = ($urandom_range(0, 4) == 0);
			for (int j = 0; j < 3; j++) begin
				lo[j] = pick_coord(wide);
				hi[j] = wide ? pick_coord(1) : lo[j] + $urandom_range(0, 32'h0002_0000);
				if ($urandom_range(0, 15) == 0)
					hi[j] = lo[j] - $urandom_range(1, 32'h0001_0000);
			end
			rad = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h0002_0000));
			send_item($urandom_range(0, 1) ? CMD_SPHERE : CMD_BOX,
				pack_item(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], rad));
		end
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	// Load all eight registers once the unit has gone idle
	task automatic load_matrix();
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= matrix_set[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			@(negedge clk);
			cfg_valid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] small_entry();
		return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
	endfunction

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_BOX;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		burst_left    = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items against the reset identity matrix (unit cube)
		send_item(CMD_BOX, '0);
		send_item(CMD_SPHERE, '0);
		send_item(CMD_BOX, pack_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
		send_item(CMD_BOX, pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
		send_item(CMD_SPHERE, pack_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
		send_item(CMD_SPHERE, pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			'0, '0, '0, '0));
		// Touching a plane exactly, and just beyond it
		send_item(CMD_BOX, pack_item(32'h0001_0000, '0, '0, 32'h0002_0000, '0, '0, '0));
		send_item(CMD_BOX, pack_item(32'h0001_0001, '0, '0, 32'h0002_0000, '0, '0, '0));
		send_item(CMD_SPHERE, pack_item(32'h0002_0000, '0, '0, '0, '0, '0, 31'h0001_0000));
		send_item(CMD_SPHERE, pack_item(32'h0002_0000, '0, '0, '0, '0, '0, 31'h0000_FFFF));
		send_item(CMD_SPHERE, pack_item('0, 32'hFFFD_0000, '0, '0, '0, '0, 31'h0002_0000));
		// Box with minimum above maximum
		send_item(CMD_BOX, pack_item(32'h0000_8000, '0, '0, 32'hFFFF_8000, '0, '0, '0));
		send_item(CMD_BOX, pack_item('0, '0, 32'hFFFE_0000, '0, '0, 32'hFFFF_0000, '0));
		send_item(CMD_BOX, pack_item('0, '0, 32'hFFFE_0000, '0, '0, 32'h0000_0001, '0));
		send_random(140);

		// Random small matrix
		for (int i = 0; i < 8; i++)
			matrix_set[i] = {small_entry(), small_entry()};
		load_matrix();
		send_random(100);

		// Saturating extremes
		for (int i = 0; i < 8; i++)
			matrix_set[i] = (i % 3 == 0) ? 64'h8000_0000_7FFF_FFFF :
				(i % 3 == 1) ? 64'h7FFF_FFFF_7FFF_FFFF : 64'h8000_0000_8000_0000;
		load_matrix();
		send_random(80);

		// All zero: every plane degenerates and nothing is culled
		for (int i = 0; i < 8; i++)
			matrix_set[i] = '0;
		load_matrix();
		send_random(40);

		// Fully random registers
		for (int i = 0; i < 8; i++)
			matrix_set[i] = {$urandom, $urandom};
		load_matrix();
		send_random(80);

		// Scaled identity with translation
		matrix_set[0] = 64'h0000_0000_0002_0000;
		matrix_set[1] = 64'h0000_0000_0000_8000;
		matrix_set[2] = 64'h0002_0000_0000_0000;
		matrix_set[3] = 64'hFFFF_8000_0000_0000;
		matrix_set[4] = '0;
		matrix_set[5] = 64'h0000_0000_0002_0000;
		matrix_set[6] = 64'h0001_0000_0000_0000;
		matrix_set[7] = 64'h0003_0000_0000_0000;
		load_matrix();
		send_random(80);

		// Back to identity
		matrix_set[0] = 64'h0000_0000_0001_0000;
		matrix_set[1] = '0;
		matrix_set[2] = 64'h0001_0000_0000_0000;
		matrix_set[3] = '0;
		matrix_set[4] = '0;
		matrix_set[5] = 64'h0000_0000_0001_0000;
		matrix_set[6] = '0;
		matrix_set[7] = 64'h0001_0000_0000_0000;
		load_matrix();
		send_random(60);

		// Drain and give the verdict
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("frustum_cull_test_unit: match");
		else
			$display("frustum_cull_test_unit: mismatch");
		$finish;
	end

endmodule
